>>> rtl/threshold_trigger_engine_defines.svh
// Assertion macros shared by the threshold trigger engine RTL.
`ifndef THRESHOLD_TRIGGER_ENGINE_DEFINES_SVH
`define THRESHOLD_TRIGGER_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define TTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

>>> rtl/tte_pkg.sv
// Shared types and constants of the threshold trigger engine.
package tte_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_STORE = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_EVAL  = 2'd3
  } cmd_e;

  localparam logic [7:0] RULE_OP_EQ = 8'd1;
  localparam logic [7:0] RULE_OP_LT = 8'd2;
  localparam logic [7:0] RULE_OP_GT = 8'd3;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 32;

  // One stored rule, 48 bits.
  typedef struct packed {
    logic signed [15:0] threshold;
    logic [7:0]         level;
    logic [7:0]         outbit;
    logic [7:0]         op;
    logic [7:0]         source;
  } rule_t;

  // One result transfer.
  typedef struct packed {
    logic [4:0]         fired_rule;
    logic               event_only;
    logic               none_fired;
    logic [3:0]         output_bits;
    logic signed [15:0] compared_reading;
    logic               last;
  } result_t;

  // Operands of the shared comparator.
  typedef struct packed {
    logic               src_ok;
    logic [7:0]         op;
    logic signed [15:0] threshold;
    logic signed [15:0] reading;
  } cmp_req_t;

endpackage

>>> rtl/tte_rule_mem.sv
// Rule table: one write port, one registered read port, per-entry valid bits.
module tte_rule_mem #(
  parameter  int unsigned RULE_COUNT = 20,
  localparam int unsigned RuleAw     = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [RuleAw-1:0]   wr_addr_i,
  input  tte_pkg::rule_t      wr_data_i,
  input  logic                rd_en_i,
  input  logic [RuleAw-1:0]   rd_addr_i,
  output tte_pkg::rule_t      rd_data_o
);

  tte_pkg::rule_t          mem_q [RULE_COUNT];
  logic [RULE_COUNT-1:0]   valid_q;
  tte_pkg::rule_t          rd_q;

  // never-written entries read as a disabled rule
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> rtl/tte_reading_bank.sv
// Reading bank: one write port, one registered read port, per-entry valid bits.
module tte_reading_bank #(
  parameter  int unsigned READING_COUNT = 17,
  localparam int unsigned RdAw          = (READING_COUNT > 1) ? $clog2(READING_COUNT) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [RdAw-1:0]     wr_addr_i,
  input  logic [15:0]         wr_data_i,
  input  logic                rd_en_i,
  input  logic [RdAw-1:0]     rd_addr_i,
  output logic [15:0]         rd_data_o
);

  logic [15:0]              mem_q [READING_COUNT];
  logic [READING_COUNT-1:0] valid_q;
  logic [15:0]              rd_q;

  // unwritten slots read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> rtl/tte_compare.sv
// Shared signed threshold comparator used for every rule of a scan.
module tte_compare (
  input  tte_pkg::cmp_req_t req_i,
  output logic              fire_o
);

  always_comb begin
    case (req_i.op)
      tte_pkg::RULE_OP_EQ: fire_o = req_i.src_ok && (req_i.threshold == req_i.reading);
      tte_pkg::RULE_OP_LT: fire_o = req_i.src_ok && (req_i.threshold > req_i.reading);
      tte_pkg::RULE_OP_GT: fire_o = req_i.src_ok && (req_i.threshold < req_i.reading);
      default:             fire_o = 1'b0;
    endcase
  end

endmodule

>>> rtl/threshold_trigger_engine.sv
// Threshold trigger engine top level: command decode, rule scan sequencer, result queue.
// Load and store write directly; count reads the slot, then writes it back incremented.
// Evaluate: the scan reads one rule and one reading per cycle through the single read
// port of the rule table and of the reading bank, stalling while a hit must push the
// held result into a full output register; the last result is registered when drained.
// Reset clears the sequencer, the output state and the valid bits of both tables at once.
`include "threshold_trigger_engine_defines.svh"

module threshold_trigger_engine #(
  parameter int unsigned RULE_COUNT    = 20,
  parameter int unsigned READING_COUNT = 17,
  parameter int unsigned OUTPUT_COUNT  = 4,
  parameter int unsigned CHANNEL_COUNT = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [4:0] rule_index, [12:5] rule_source, [20:13] rule_operator, [28:21] rule_output,
  // [36:29] rule_level, [52:37] rule_threshold, [57:53] reading_slot,
  // [73:58] reading_value, [76:74] pulse_channel, [79:77] zero
  input  logic [tte_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]                     s_axis_tuser,
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [4:0] fired_rule, [8:5] output_bits, [24:9] compared_reading, [31:25] zero
  output logic [tte_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] event_only, [1] none_fired
  output logic [1:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int unsigned RuleAw = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
  localparam int unsigned RdAw   = (READING_COUNT > 1) ? $clog2(READING_COUNT) : 1;
  localparam int unsigned IdxW   = $clog2(RULE_COUNT + 1);
  // Output state is at least as wide as the output_bits field.
  localparam int unsigned StateW = (OUTPUT_COUNT > 4) ? OUTPUT_COUNT : 4;
  localparam int unsigned OutAw  = $clog2(StateW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_EVAL
  } state_e;

  // ---------------------------------------------------------------- input unpack
  logic [4:0]         in_rule_index;
  tte_pkg::rule_t     in_rule;
  logic [4:0]         in_slot;
  logic [15:0]        in_value;
  logic [2:0]         in_channel;
  tte_pkg::cmd_e      in_cmd;
  logic               in_xfer;

  assign in_rule_index    = s_axis_tdata[4:0];
  assign in_rule.source   = s_axis_tdata[12:5];
  assign in_rule.op       = s_axis_tdata[20:13];
  assign in_rule.outbit   = s_axis_tdata[28:21];
  assign in_rule.level    = s_axis_tdata[36:29];
  assign in_rule.threshold = s_axis_tdata[52:37];
  assign in_slot          = s_axis_tdata[57:53];
  assign in_value         = s_axis_tdata[73:58];
  assign in_channel       = s_axis_tdata[76:74];
  assign in_cmd           = tte_pkg::cmd_e'(s_axis_tuser);

  // ---------------------------------------------------------------- registers
  state_e             state_q, state_d;
  logic [IdxW-1:0]    idx_q, idx_d;           // next rule to read
  logic               s1_q, s1_d;             // rule data valid at table output
  logic [RuleAw-1:0]  s1_idx_q, s1_idx_d;
  logic               s2_q, s2_d;             // reading valid, rule ready to compare
  logic [RuleAw-1:0]  s2_idx_q, s2_idx_d;
  tte_pkg::rule_t     s2_rule_q, s2_rule_d;
  logic               pend_valid_q, pend_valid_d;
  tte_pkg::result_t   pend_q, pend_d;         // newest hit, held until its last flag is known
  logic               out_valid_q, out_valid_d;
  tte_pkg::result_t   out_q, out_d;
  logic [StateW-1:0]  out_state_q, out_state_d;
  logic [RdAw-1:0]    cnt_addr_q, cnt_addr_d;

  // Sequential block: one command in flight, new transfers only while idle.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- memories
  logic               rule_we, rule_re;
  logic [RuleAw-1:0]  rule_wr_addr;
  tte_pkg::rule_t     rule_rd;
  logic               bank_we, bank_re;
  logic [RdAw-1:0]    bank_wr_addr, bank_rd_addr;
  logic [15:0]        bank_wr_data, bank_rd;

  assign rule_wr_addr = RuleAw'(in_rule_index);

  tte_rule_mem #(
    .RULE_COUNT (RULE_COUNT)
  ) u_rule_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (rule_we),
    .wr_addr_i (rule_wr_addr),
    .wr_data_i (in_rule),
    .rd_en_i   (rule_re),
    .rd_addr_i (RuleAw'(idx_q)),
    .rd_data_o (rule_rd)
  );

  tte_reading_bank #(
    .READING_COUNT (READING_COUNT)
  ) u_reading_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (bank_we),
    .wr_addr_i (bank_wr_addr),
    .wr_data_i (bank_wr_data),
    .rd_en_i   (bank_re),
    .rd_addr_i (bank_rd_addr),
    .rd_data_o (bank_rd)
  );

  // ---------------------------------------------------------------- comparator
  tte_pkg::cmp_req_t  cmp_req;
  logic               cmp_fire;

  assign cmp_req.src_ok    = (9'(s2_rule_q.source) < 9'(READING_COUNT));
  assign cmp_req.op        = s2_rule_q.op;
  assign cmp_req.threshold = s2_rule_q.threshold;
  assign cmp_req.reading   = bank_rd;

  tte_compare u_compare (
    .req_i  (cmp_req),
    .fire_o (cmp_fire)
  );

  // ---------------------------------------------------------------- control
  logic               issue;      // rules left to read
  logic               hit;        // stage 2 rule fires this cycle
  logic               out_free;   // output register can take a result
  logic               advance;    // scan pipeline moves
  logic               drive_ok;   // hit rule names a real output bit
  logic [OutAw-1:0]   drive_bit;
  logic [StateW-1:0]  hit_state;
  logic [RdAw-1:0]    count_slot;
  logic               count_ok;

  assign issue      = (idx_q < IdxW'(RULE_COUNT));
  assign hit        = s2_q && cmp_fire;
  assign out_free   = !out_valid_q || m_axis_tready;
  // stall only when a hit must push the held result and the output is still full
  assign advance    = !(hit && pend_valid_q && !out_free);
  assign drive_ok   = (9'(s2_rule_q.outbit) < 9'(OUTPUT_COUNT));
  assign drive_bit  = OutAw'(s2_rule_q.outbit);
  assign count_slot = RdAw'({in_channel, 1'b0});
  assign count_ok   = (6'(in_channel) < 6'(CHANNEL_COUNT)) &&
                      (7'({in_channel, 1'b0}) < 7'(READING_COUNT));

  always_comb begin
    hit_state = out_state_q;
    if (drive_ok) begin
      hit_state[drive_bit] = (s2_rule_q.level != 8'd0);
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    s1_d         = s1_q;
    s1_idx_d     = s1_idx_q;
    s2_d         = s2_q;
    s2_idx_d     = s2_idx_q;
    s2_rule_d    = s2_rule_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_state_d  = out_state_q;
    cnt_addr_d   = cnt_addr_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_d        = out_q;
    rule_we      = 1'b0;
    rule_re      = 1'b0;
    bank_we      = 1'b0;
    bank_re      = 1'b0;
    bank_wr_addr = RdAw'(in_slot);
    bank_wr_data = in_value;
    bank_rd_addr = RdAw'(rule_rd.source);

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_cmd)
            tte_pkg::CMD_LOAD: begin
              rule_we = (6'(in_rule_index) < 6'(RULE_COUNT));
            end
            tte_pkg::CMD_STORE: begin
              bank_we = (7'(in_slot) < 7'(READING_COUNT));
            end
            tte_pkg::CMD_COUNT: begin
              if (count_ok) begin
                bank_re      = 1'b1;
                bank_rd_addr = count_slot;
                cnt_addr_d   = count_slot;
                state_d      = ST_COUNT;
              end
            end
            tte_pkg::CMD_EVAL: begin
              idx_d        = '0;
              s1_d         = 1'b0;
              s2_d         = 1'b0;
              pend_valid_d = 1'b0;
              state_d      = ST_EVAL;
            end
          endcase
        end
      end

      ST_COUNT: begin
        bank_we      = 1'b1;
        bank_wr_addr = cnt_addr_q;
        bank_wr_data = 16'(bank_rd + 16'd1);
        state_d      = ST_IDLE;
      end

      ST_EVAL: begin
        if (!issue && !s1_q && !s2_q) begin
          // scan drained: flag the held hit as last, or report that none fired
          if (out_free) begin
            out_valid_d = 1'b1;
            if (pend_valid_q) begin
              out_d      = pend_q;
              out_d.last = 1'b1;
            end else begin
              out_d.fired_rule       = '0;
              out_d.event_only       = 1'b0;
              out_d.none_fired       = 1'b1;
              out_d.output_bits      = out_state_q[3:0];
              out_d.compared_reading = '0;
              out_d.last             = 1'b1;
            end
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end else if (advance) begin
          rule_re   = issue;
          s1_d      = issue;
          if (issue) begin
            idx_d    = idx_q + IdxW'(1);
            s1_idx_d = RuleAw'(idx_q);
          end
          bank_re   = s1_q;
          s2_d      = s1_q;
          s2_idx_d  = s1_idx_q;
          s2_rule_d = rule_rd;
          if (hit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
            end
            out_state_d             = hit_state;
            pend_valid_d            = 1'b1;
            pend_d.fired_rule       = 5'(s2_idx_q);
            pend_d.event_only       = !drive_ok;
            pend_d.none_fired       = 1'b0;
            pend_d.output_bits      = hit_state[3:0];
            pend_d.compared_reading = bank_rd;
            pend_d.last             = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      s1_q         <= 1'b0;
      s1_idx_q     <= '0;
      s2_q         <= 1'b0;
      s2_idx_q     <= '0;
      s2_rule_q    <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      out_state_q  <= '0;
      cnt_addr_q   <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      s1_q         <= s1_d;
      s1_idx_q     <= s1_idx_d;
      s2_q         <= s2_d;
      s2_idx_q     <= s2_idx_d;
      s2_rule_q    <= s2_rule_d;
      pend_valid_q <= pend_valid_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
      out_state_q  <= out_state_d;
      cnt_addr_q   <= cnt_addr_d;
    end
  end

  // ---------------------------------------------------------------- output pack
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.compared_reading, out_q.output_bits, out_q.fired_rule};
  assign m_axis_tuser  = {out_q.none_fired, out_q.event_only};
  assign m_axis_tlast  = out_q.last;

  // ---------------------------------------------------------------- checks
  // a none-fired result is always the only, hence last, result of its scan
  `TTE_ASSERT_IMP(a_none_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
  // a held hit only exists while a scan runs, so no transfer is taken then
  `TTE_ASSERT_IMP(a_pend_blocks_input, clk_i, rst_ni, pend_valid_q, !s_axis_tready)
  // an evaluate transfer always starts a multi-cycle scan
  `TTE_ASSERT_NXT(a_eval_busy, clk_i, rst_ni, in_xfer && (in_cmd == tte_pkg::CMD_EVAL), !s_axis_tready)

endmodule

>>> tb/trigger_result_checker.sv
// Result checker for the threshold trigger engine: mirrors rule and reading state, checks results.
package tte_tb_pkg;

  // Input transfer payload, lowest field last.
  typedef struct packed {
    logic [2:0]         pad;
    logic [2:0]         channel;
    logic signed [15:0] value;
    logic [4:0]         slot;
    logic signed [15:0] threshold;
    logic [7:0]         level;
    logic [7:0]         outbit;
    logic [7:0]         op;
    logic [7:0]         source;
    logic [4:0]         index;
  } cmd_word_t;

endpackage

module trigger_result_checker #(
  parameter int unsigned RULE_COUNT    = 20,
  parameter int unsigned READING_COUNT = 17,
  parameter int unsigned OUTPUT_COUNT  = 4,
  parameter int unsigned CHANNEL_COUNT = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [tte_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic [1:0]                     s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [tte_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input  logic [1:0]                     m_tuser_i,
  input  logic                           m_tlast_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             results_o,
  output int                             events_o,
  output int                             idle_results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  tte_pkg::rule_t          rule_mem    [RULE_COUNT];
  logic signed [15:0]      reading_mem [READING_COUNT];
  logic [OUTPUT_COUNT-1:0] out_state;
  tte_pkg::result_t        expected_results [$];

  // Mirror one accepted command; an evaluate queues its results.
  task automatic predict_command(input tte_pkg::cmd_e cmd, input tte_tb_pkg::cmd_word_t w);
    int unsigned        slot2;
    bit                 any_fired;
    bit                 hit;
    tte_pkg::rule_t     ru;
    tte_pkg::result_t   res;
    logic signed [15:0] rd;
    case (cmd)
      tte_pkg::CMD_LOAD: begin
        if (w.index < RULE_COUNT)
          rule_mem[w.index] = '{threshold: w.threshold, level: w.level, outbit: w.outbit,
                                op: w.op, source: w.source};
      end
      tte_pkg::CMD_STORE: begin
        if (w.slot < READING_COUNT) reading_mem[w.slot] = w.value;
      end
      tte_pkg::CMD_COUNT: begin
        slot2 = 2 * w.channel;
        if (w.channel < CHANNEL_COUNT && slot2 < READING_COUNT)
          reading_mem[slot2] = reading_mem[slot2] + 16'sd1;
      end
      default: begin
        any_fired = 1'b0;
        for (int i = 0; i < RULE_COUNT; i++) begin
          ru = rule_mem[i];
          if (ru.source >= READING_COUNT) continue;
          rd = reading_mem[ru.source];
          case (ru.op)
            tte_pkg::RULE_OP_EQ: hit = (ru.threshold == rd);
            tte_pkg::RULE_OP_LT: hit = (ru.threshold > rd);
            tte_pkg::RULE_OP_GT: hit = (ru.threshold < rd);
            default:             hit = 1'b0;
          endcase
          if (!hit) continue;
          res = '0;
          res.fired_rule = 5'(i);
          res.event_only = (ru.outbit >= OUTPUT_COUNT);
          if (!res.event_only) out_state[ru.outbit] = (ru.level != 8'd0);
          res.output_bits      = 4'(out_state);
          res.compared_reading = rd;
          expected_results.push_back(res);
          any_fired = 1'b1;
        end
        if (any_fired) begin
          expected_results[expected_results.size() - 1].last = 1'b1;
        end else begin
          res = '0;
          res.none_fired  = 1'b1;
          res.output_bits = 4'(out_state);
          res.last        = 1'b1;
          expected_results.push_back(res);
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_result();
    tte_pkg::result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result transfer: tdata %h tuser %b tlast %b",
             m_tdata_i, m_tuser_i, m_tlast_i);
      fail_count_o++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("fired_rule", want.fired_rule, m_tdata_i[4:0]);
    compare_field("event_only", want.event_only, m_tuser_i[0]);
    compare_field("none_fired", want.none_fired, m_tuser_i[1]);
    compare_field("output_bits", want.output_bits, m_tdata_i[8:5]);
    compare_field("compared_reading", want.compared_reading, $signed(m_tdata_i[24:9]));
    compare_field("last", want.last, m_tlast_i);
    results_o++;
    if (want.event_only) events_o++;
    if (want.none_fired) idle_results_o++;
  endtask

  // Result side first: a result never belongs to a command taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RULE_COUNT; i++) rule_mem[i] = '0;
      for (int i = 0; i < READING_COUNT; i++) reading_mem[i] = '0;
      out_state = '0;
      expected_results.delete();
      fail_count_o   = 0;
      results_o      = 0;
      events_o       = 0;
      idle_results_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_result();
      if (s_tvalid_i && s_tready_i)
        predict_command(tte_pkg::cmd_e'(s_tuser_i), tte_tb_pkg::cmd_word_t'(s_tdata_i));
    end
    pending_o = expected_results.size();
  end

endmodule

>>> tb/tb.sv
// Stimulus and verdict for the threshold trigger engine testbench.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RULE_COUNT   = 20;
  localparam int unsigned RANDOM_ITEMS = 259;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 2 * (RULE_COUNT + 4);
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  logic                           clk      = 1'b0;
  logic                           rst_n    = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic [tte_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
  logic [1:0]                     s_tuser  = '0;
  logic                           m_tready = 1'b0;
  logic                           s_tready;
  logic                           m_tvalid;
  logic [tte_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [1:0]                     m_tuser;
  logic                           m_tlast;

  int fail_count, pending, results, events, idle_results;
  int loads, stores, counts, evals;
  int send_calm  = 0;
  int hold_asked = 0;

  threshold_trigger_engine dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  trigger_result_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .s_tuser_i      (s_tuser),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .m_tuser_i      (m_tuser),
    .m_tlast_i      (m_tlast),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .events_o       (events),
    .idle_results_o (idle_results)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
    $display("FAIL threshold_trigger_engine");
    $finish;
  end

  // Mostly no gap, some short, a few long; now and then a calm stretch with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // Values clustered near zero and the extremes so equality rules hit often.
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:             return 16'sh8000;
      1:             return 16'sh7fff;
      2, 3, 4, 5:    return 16'(int'($urandom_range(0, 6)) - 3);
      default:       return 16'($urandom);
    endcase
  endfunction

  // Unused fields carry random noise so every payload bit but the zero pad toggles.
  function automatic tte_tb_pkg::cmd_word_t noise_word();
    tte_tb_pkg::cmd_word_t w;
    w = 80'({$urandom, $urandom, $urandom});
    w.pad = '0;
    return w;
  endfunction

  task automatic send_command(input tte_pkg::cmd_e cmd, input tte_tb_pkg::cmd_word_t w);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    case (cmd)
      tte_pkg::CMD_LOAD:  loads++;
      tte_pkg::CMD_STORE: stores++;
      tte_pkg::CMD_COUNT: counts++;
      default:            evals++;
    endcase
  endtask

  task automatic load_rule(input logic [4:0] idx, input logic [7:0] src, input logic [7:0] op,
                           input logic [7:0] outb, input logic [7:0] lvl,
                           input logic signed [15:0] thr);
    tte_tb_pkg::cmd_word_t w;
    w = noise_word();
    w.index     = idx;
    w.source    = src;
    w.op        = op;
    w.outbit    = outb;
    w.level     = lvl;
    w.threshold = thr;
    send_command(tte_pkg::CMD_LOAD, w);
  endtask

  task automatic store_reading(input logic [4:0] slot, input logic signed [15:0] val);
    tte_tb_pkg::cmd_word_t w;
    w = noise_word();
    w.slot  = slot;
    w.value = val;
    send_command(tte_pkg::CMD_STORE, w);
  endtask

  task automatic count_pulse(input logic [2:0] ch);
    tte_tb_pkg::cmd_word_t w;
    w = noise_word();
    w.channel = ch;
    send_command(tte_pkg::CMD_COUNT, w);
  endtask

  task automatic evaluate_rules();
    send_command(tte_pkg::CMD_EVAL, noise_word());
  endtask

  task automatic random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28)
      load_rule(5'(($urandom_range(0, 99) < 88) ? $urandom_range(0, 19) : $urandom_range(20, 31)),
                8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 16) : $urandom),
                8'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom),
                8'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom),
                8'(($urandom_range(0, 99) < 45) ? 0 : $urandom),
                pick_value());
    else if (r < 52)
      store_reading(5'(($urandom_range(0, 99) < 90) ? $urandom_range(0, 16)
                                                    : $urandom_range(17, 31)), pick_value());
    else if (r < 66)
      count_pulse(3'($urandom_range(0, 7)));
    else
      evaluate_rules();
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall, hold, calm, seen;
    stall = 0;
    hold  = 0;
    calm  = 0;
    seen  = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (seen != hold_asked) begin
        seen = hold_asked;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        stall = pick_gap(calm);
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fresh table: all rules disabled
    evaluate_rules();
    load_rule(5'd0, 8'd0, tte_pkg::RULE_OP_EQ, 8'd0, 8'd1, 16'sd0);
    load_rule(5'd31, 8'd0, tte_pkg::RULE_OP_EQ, 8'd1, 8'd1, 16'sd0);    // past the table
    load_rule(5'd20, 8'd0, tte_pkg::RULE_OP_EQ, 8'd1, 8'd1, 16'sd0);    // past the table
    load_rule(5'd1, 8'd17, tte_pkg::RULE_OP_EQ, 8'd1, 8'd1, 16'sd0);    // source out of range
    load_rule(5'd2, 8'd255, tte_pkg::RULE_OP_GT, 8'd2, 8'd1, 16'sh8000);
    load_rule(5'd3, 8'd0, 8'd0, 8'd1, 8'd1, 16'sd0);                    // meaningless operators
    load_rule(5'd4, 8'd0, 8'd255, 8'd1, 8'd1, 16'sd0);
    load_rule(5'd19, 8'd16, tte_pkg::RULE_OP_LT, 8'd255, 8'd0, 16'sh7fff); // event only
    store_reading(5'd16, 16'sh8000);
    store_reading(5'd17, 16'sd1);                                       // past the bank
    store_reading(5'd31, 16'sd7);
    store_reading(5'd2, 16'sh7fff);
    load_rule(5'd5, 8'd2, tte_pkg::RULE_OP_GT, 8'd3, 8'd255, 16'sd32766);
    evaluate_rules();
    count_pulse(3'd1);                                                  // counter wraps
    count_pulse(3'd0);
    count_pulse(3'd7);
    load_rule(5'd6, 8'd0, tte_pkg::RULE_OP_EQ, 8'd0, 8'd0, 16'sd1);     // clears a set bit
    load_rule(5'd7, 8'd14, tte_pkg::RULE_OP_EQ, 8'd2, 8'd1, 16'sd1);
    evaluate_rules();

    // every rule fires, results pile up behind a long hold-off
    store_reading(5'd16, 16'sd0);
    for (int i = 0; i < RULE_COUNT; i++)
      load_rule(5'(i), 8'd16, tte_pkg::RULE_OP_EQ, 8'(i % 6), 8'(i % 2), 16'sd0);
    hold_asked++;
    send_calm = 60;
    repeat (8) evaluate_rules();

    repeat (RANDOM_ITEMS) random_command();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transfers: %0d rule loads, %0d stores, %0d counts, %0d evaluates.",
             loads + stores + counts + evals, loads, stores, counts, evals);
    $display("Checked %0d results (%0d event-only, %0d none-fired), random stalls, %0d-cycle hold.",
             results, events, idle_results, HOLD_CYCLES);
    if (fail_count == 0)
      $display("PASS threshold_trigger_engine");
    else
      $display("FAIL threshold_trigger_engine");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/tte_pkg.sv
rtl/tte_rule_mem.sv
rtl/tte_reading_bank.sv
rtl/tte_compare.sv
rtl/threshold_trigger_engine.sv
tb/trigger_result_checker.sv
tb/tb.sv
